### sv/base64_decoder_assert.svh
`ifndef BASE64_DECODER_ASSERT_SVH
`define BASE64_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define B64D_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("b64d assertion failed");

// Next-cycle implication, disabled while in reset.
`define B64D_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("b64d assertion failed");

`endif

### sv/b64d_pkg.sv
package b64d_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_PUSH   = 3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       last;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c inside {[8'h09:8'h0D]});
    endfunction

    // {invalid, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'd0;
        r = {1'b1, 6'd0};
        if (c inside {[8'h41:8'h5A]}) begin
            d = c - 8'h41;
            r = {1'b0, d[5:0]};
        end else if (c inside {[8'h61:8'h7A]}) begin
            d = c - 8'h61 + 8'd26;
            r = {1'b0, d[5:0]};
        end else if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30 + 8'd52;
            r = {1'b0, d[5:0]};
        end else if (c == CHAR_PLUS) begin
            r = {1'b0, 6'd62};
        end else if (c == CHAR_SLASH) begin
            r = {1'b0, 6'd63};
        end
        return r;
    endfunction

endpackage

### sv/base64_decoder.sv
// Streaming Base64 decoder (standard alphabet). One character is taken per
// transfer on the s_ side, one character per cycle while s_tready is high; whitespace is
// skipped, every fourth non-whitespace character releases up to three bytes,
// and the character flagged by s_tlast closes the message with a final
// result that carries the status (ok, bad character, or bad length, which
// wins over bad character). Results are registered into an 8-entry result
// queue and leave it in order on the m_ side, one per
// transfer; s_tready is low only while fewer than three queue entries are
// free, which happens only when the m_ side stalls. On any nonzero status
// the whole message should be dropped downstream.
`include "base64_decoder_assert.svh"

module base64_decoder import b64d_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_char
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [2:0] m_tuser,   // [0] byte_valid, [2:1] status
    output logic       m_tlast    // last
);

    logic [1:0]  gp_reg, gp_next;
    logic [17:0] held_reg, held_next;
    logic        tpad_reg, tpad_next;
    logic        bad_reg, bad_next;

    result_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic        s_fire, m_fire;
    logic        space, pad, bad_now, complete, bad_acc, p1, p2;
    logic [6:0]  sx;
    logic [5:0]  v;
    logic [23:0] word;
    logic [1:0]  gp_after, status;
    logic [1:0]  push_cnt;
    result_t     ent [MAX_PUSH];

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign s_tready = count_reg <= CNT_W'(FIFO_DEPTH - MAX_PUSH);
    assign m_tvalid = count_reg != '0;

    assign m_tdata  = mem_reg[rptr_reg].data_byte;
    assign m_tuser  = {mem_reg[rptr_reg].status, mem_reg[rptr_reg].byte_valid};
    assign m_tlast  = mem_reg[rptr_reg].last;

    always_comb begin
        space    = is_space(s_tdata);
        pad      = (s_tdata == CHAR_PAD) && gp_reg[1];
        sx       = sextet_of(s_tdata);
        bad_now  = !space && !pad && sx[6];
        v        = (pad || sx[6]) ? 6'd0 : sx[5:0];
        bad_acc  = bad_reg || bad_now;
        complete = !space && (gp_reg == 2'd3);
        word     = {held_reg, v};
        p1       = !tpad_reg;
        p2       = !pad;

        if (space)         gp_after = gp_reg;
        else if (complete) gp_after = 2'd0;
        else               gp_after = gp_reg + 2'd1;

        if (gp_after != 2'd0) status = STATUS_BAD_LEN;
        else if (bad_acc)     status = STATUS_BAD_CHAR;
        else                  status = STATUS_OK;

        for (int i = 0; i < MAX_PUSH; i++) begin
            ent[i] = '{data_byte: 8'd0, byte_valid: 1'b0, status: STATUS_OK, last: 1'b0};
        end

        push_cnt = 2'd0;
        if (complete && !bad_acc) begin
            ent[0].data_byte  = word[23:16];
            ent[0].byte_valid = 1'b1;
            ent[1].data_byte  = p1 ? word[15:8] : word[7:0];
            ent[1].byte_valid = 1'b1;
            ent[2].data_byte  = word[7:0];
            ent[2].byte_valid = 1'b1;
            push_cnt = 2'd1 + {1'b0, p1} + {1'b0, p2};
            if (s_tlast) begin
                ent[push_cnt - 2'd1].status = status;
                ent[push_cnt - 2'd1].last   = 1'b1;
            end
        end else if (s_tlast) begin
            ent[0].status = status;
            ent[0].last   = 1'b1;
            push_cnt = 2'd1;
        end
        if (!s_fire) push_cnt = 2'd0;

        gp_next   = gp_reg;
        held_next = held_reg;
        tpad_next = tpad_reg;
        bad_next  = bad_reg;
        if (s_fire) begin
            if (s_tlast) begin
                gp_next   = 2'd0;
                held_next = 18'd0;
                tpad_next = 1'b0;
                bad_next  = 1'b0;
            end else if (!space) begin
                gp_next  = gp_after;
                bad_next = bad_acc;
                if (complete) begin
                    held_next = 18'd0;
                    tpad_next = 1'b0;
                end else begin
                    held_next = {held_reg[11:0], v};
                    if (gp_reg == 2'd2) tpad_next = pad;
                end
            end
        end

        wptr_next  = wptr_reg + PTR_W'(push_cnt);
        rptr_next  = rptr_reg + PTR_W'(m_fire);
        count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gp_reg    <= 2'd0;
            held_reg  <= 18'd0;
            tpad_reg  <= 1'b0;
            bad_reg   <= 1'b0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            gp_reg    <= gp_next;
            held_reg  <= held_next;
            tpad_reg  <= tpad_next;
            bad_reg   <= bad_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (PTR_W'(i) < PTR_W'(push_cnt)) begin
                mem_reg[wptr_reg + PTR_W'(i)] <= ent[i];
            end
        end
    end

    `B64D_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))
    `B64D_ASSERT_NXT(a_eot_clears, s_fire && s_tlast,
                     gp_reg == 2'd0 && !bad_reg && !tpad_reg && held_reg == 18'd0)
    `B64D_ASSERT_NXT(a_eot_pushes, s_fire && s_tlast && !m_fire,
                     count_reg > $past(count_reg))
    `B64D_ASSERT_IMP(a_status_on_last, m_tvalid && m_tuser[2:1] != STATUS_OK, m_tlast)
    `B64D_ASSERT_IMP(a_empty_on_last, m_tvalid && !m_tuser[0], m_tlast)

endmodule

### tb/testbench.sv
module testbench import b64d_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    localparam int RANDOM_ITEMS = 470;
    localparam int HOLD_CYCLES  = 150;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    text_item_t chars_to_send[$];
    result_t    bytes_due[$];

    int  total_items = 0;
    int  accepted = 0;
    int  errors = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  s_fire = 1'b0;

    // decoder state mirror
    logic [1:0]  grp_pos = '0;
    logic [17:0] sextets = '0;
    logic        pad3 = 1'b0;
    logic        bad_seen = 1'b0;

    base64_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // {not_in_alphabet, value}
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 26)};
        if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 52)};
        if (c == CHAR_PLUS) return {1'b0, 6'd62};
        if (c == CHAR_SLASH) return {1'b0, 6'd63};
        return {1'b1, 6'd0};
    endfunction

    function automatic logic [7:0] b64_char(input int v);
        if (v < 26) return 8'(v + "A");
        if (v < 52) return 8'(v - 26 + "a");
        if (v < 62) return 8'(v - 52 + "0");
        return (v == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CHAR_SPACE : 8'(8'h09 + r);
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic eot);
        logic [7:0]  out_bytes[3];
        logic [6:0]  look;
        logic [5:0]  v;
        logic [23:0] word;
        logic [1:0]  st;
        result_t     r;
        bit          pad;
        int          nb;
        nb = 0;
        if (!is_blank(c)) begin
            pad = (c == CHAR_PAD) && (grp_pos >= 2);
            look = char_to_sextet(c);
            v = pad ? 6'd0 : look[5:0];
            if (!pad && look[6]) begin
                bad_seen = 1'b1;
                v = 6'd0;
            end
            if (grp_pos == 2) pad3 = pad;
            if (grp_pos < 3) begin
                sextets = {sextets[11:0], v};
                grp_pos = grp_pos + 2'd1;
            end else begin
                word = {sextets, v};
                if (!bad_seen) begin
                    out_bytes[nb] = word[23:16];
                    nb = nb + 1;
                    if (!pad3) begin
                        out_bytes[nb] = word[15:8];
                        nb = nb + 1;
                    end
                    if (!pad) begin
                        out_bytes[nb] = word[7:0];
                        nb = nb + 1;
                    end
                end
                sextets = '0;
                pad3 = 1'b0;
                grp_pos = '0;
            end
        end
        st = STATUS_OK;
        if (eot) begin
            if (grp_pos != 0) st = STATUS_BAD_LEN;
            else if (bad_seen) st = STATUS_BAD_CHAR;
        end
        for (int i = 0; i < nb; i++) begin
            r.data_byte  = out_bytes[i];
            r.byte_valid = 1'b1;
            r.last       = eot && (i == nb - 1);
            r.status     = r.last ? st : STATUS_OK;
            bytes_due = {bytes_due, r};
        end
        if (eot) begin
            if (nb == 0) begin
                r.data_byte  = 8'd0;
                r.byte_valid = 1'b0;
                r.status     = st;
                r.last       = 1'b1;
                bytes_due = {bytes_due, r};
            end
            grp_pos = '0;
            sextets = '0;
            pad3 = 1'b0;
            bad_seen = 1'b0;
        end
    endfunction

    function automatic void push_item(input logic [7:0] c, input logic eot);
        text_item_t t;
        t.ch = c;
        t.eot = eot;
        chars_to_send = {chars_to_send, t};
    endfunction

    function automatic void push_string(input string s, input bit eot_on_last);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], eot_on_last && (i == s.len() - 1));
    endfunction

    // mostly well-formed messages; broken ones get one char dropped, added or corrupted
    function automatic void add_message(input bit broken);
        logic [7:0] txt[$];
        int ngroups, npad, idx;
        bit trail;
        ngroups = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 3);
        for (int k = 0; k < ngroups; k++) begin
            for (int j = 0; j < 4; j++) txt = {txt, b64_char($urandom_range(0, 63))};
            npad = (k == ngroups - 1 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 0;
            if (npad == 1 || npad == 2) txt[txt.size() - 1] = CHAR_PAD;
            if (npad >= 2) txt[txt.size() - 2] = CHAR_PAD;
        end
        if (broken) begin
            if (txt.size() == 0) begin
                txt = {txt, 8'($urandom_range(0, 255))};
            end else begin
                idx = $urandom_range(0, txt.size() - 1);
                case ($urandom_range(0, 2))
                    0: txt.delete(idx);
                    1: txt.insert(idx, b64_char($urandom_range(0, 63)));
                    default: txt[idx] = 8'($urandom_range(0, 255));
                endcase
            end
        end
        trail = (txt.size() == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < txt.size(); i++) begin
            if ($urandom_range(0, 7) == 0) push_item(blank_char(), 1'b0);
            push_item(txt[i], !trail && (i == txt.size() - 1));
        end
        if (trail) push_item(blank_char(), 1'b1);
    endfunction

    function automatic void add_noise(input bit mixed);
        int n, r;
        logic [7:0] c;
        n = $urandom_range(1, mixed ? 12 : 8);
        for (int i = 0; i < n; i++) begin
            if (!mixed) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                r = $urandom_range(0, 3);
                c = (r == 0) ? CHAR_PAD : (r == 1) ? blank_char() : b64_char($urandom_range(0, 63));
            end
            push_item(c, i == n - 1);
        end
    endfunction

    function automatic int pct_for(input bit sender);
        int phase;
        phase = (accepted < total_items / 3) ? 0 : (accepted < 2 * total_items / 3) ? 1 : 2;
        if (phase == 2) return 0;
        return ((phase == 0) == sender) ? 24 : 77;
    endfunction

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (chars_to_send.size() > 0 && $urandom_range(0, 99) >= pct_for(1'b1)) begin
                s_tdata  <= chars_to_send[0].ch;
                s_tlast  <= chars_to_send[0].eot;
                s_tvalid <= 1'b1;
                void'(chars_to_send.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result-side ready, with one long hold-off while input is still offered
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && accepted >= 2 * total_items / 3 + 20) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= pct_for(1'b0));
        end
    end

    // monitor: check results, then predict from the input transfer
    always @(posedge aclk) begin
        result_t want;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (bytes_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: data %02h user %b last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = bytes_due.pop_front();
                if (m_tdata !== want.data_byte || m_tuser[0] !== want.byte_valid ||
                    m_tuser[2:1] !== want.status || m_tlast !== want.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp data %02h valid %b status %0d last %b, got data %02h valid %b status %0d last %b",
                                 want.data_byte, want.byte_valid, want.status, want.last,
                                 m_tdata, m_tuser[0], m_tuser[2:1], m_tlast);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            accepted <= accepted + 1;
            decode_char(s_tdata, s_tlast);
        end
    end

    initial begin
        push_string("T\tQ\n=\v=\f+/az", 1'b0);
        push_item(8'h0D, 1'b0);
        push_string("09Z=", 1'b0);
        push_item(CHAR_SPACE, 1'b1);
        push_string("TQ=A", 1'b1);
        push_item(8'h80, 1'b0);
        push_item(CHAR_PAD, 1'b0);
        push_item("B", 1'b0);
        push_item(8'hFF, 1'b1);
        push_item("A", 1'b0);
        push_item(8'h00, 1'b1);
        push_item(CHAR_SPACE, 1'b1);
        while (chars_to_send.size() < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                7: add_message(1'b1);
                8: add_noise(1'b0);
                9: add_noise(1'b1);
                default: add_message(1'b0);
            endcase
        end
        total_items = chars_to_send.size();
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        while (chars_to_send.size() != 0 || s_tvalid) @(posedge aclk);
        while (bytes_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("base64_decoder verification clean");
        else
            $display("base64_decoder verification failed");
        $finish;
    end

    initial begin
        #3ms;
        $display("base64_decoder verification failed");
        $finish;
    end

endmodule
